FILE: rtl/core/rvn_pkg.sv
// Shared types and constants of the RMS vector normaliser.
package rvn_pkg;

  localparam int MaxHiddenDef = 64;
  localparam int WIDX_W      = 6;
  localparam int DATA_W      = 16;
  localparam int SUM_W       = 36;
  localparam int CNT_W       = 7;
  localparam int EPS_W       = 24;
  localparam int MS_W        = 37;
  localparam int DIVD_W      = 57;
  localparam int ROOT_W      = 29;
  localparam int DIV_STEPS   = 57;
  localparam int SQRT_STEPS  = 29;
  localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [2:0] ADDR_EPS = 3'd0;

  typedef struct packed {
    logic                     cmd;
    logic [WIDX_W-1:0]        weight_index;
    logic signed [DATA_W-1:0] data_value;
    logic                     last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_value;
    logic                     last_out;
  } out_word_t;

  // store write request from front to back
  typedef struct packed {
    logic              we_w;
    logic              we_x;
    logic [WIDX_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

  // one finished row: square sum and sample count
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } job_t;

endpackage

FILE: rtl/core/rvn_front.sv
// Front end: accept words, write stores, accumulate squares, post rows.
module rvn_front import rvn_pkg::*; #(
  parameter int MAX_HIDDEN = MaxHiddenDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_word_t word,
  output wr_t      wr,
  output logic     push,
  output job_t     job
);

  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [CNT_W-1:0]    cnt_nxt;
  logic signed [31:0]  sq;
  logic                is_smp;
  logic                row_end;

  assign is_smp  = acc && (word.cmd == CMD_SAMPLE);
  assign sq      = word.data_value * word.data_value;
  assign sum_nxt = sum_r + {4'd0, sq};
  assign cnt_nxt = cnt_r + 7'd1;
  assign row_end = word.last_sample || (cnt_nxt == CNT_W'(MAX_HIDDEN));

  always_comb begin
    wr.we_w = acc && (word.cmd == CMD_WEIGHT) &&
              ({26'd0, word.weight_index} < 32'(MAX_HIDDEN));
    wr.we_x = is_smp;
    wr.addr = (word.cmd == CMD_WEIGHT) ? word.weight_index : cnt_r[WIDX_W-1:0];
    wr.data = word.data_value;
  end

  assign push      = is_smp && row_end;
  assign job.sum   = sum_nxt;
  assign job.count = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (is_smp) begin
      if (row_end) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/rvn_queue.sv
// Two-entry queue of finished rows between front and back.
module rvn_queue import rvn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic empty,
  output logic full
);

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

endmodule

FILE: rtl/core/rvn_back.sv
// Back end: stores, shared divider and root unit, and the scaling pipeline.
module rvn_back import rvn_pkg::*; #(
  parameter int MAX_HIDDEN = MaxHiddenDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wr_t              wr,
  input  logic [EPS_W-1:0] eps,
  input  logic             q_empty,
  input  job_t             q_job,
  output logic             q_pop,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  localparam int IDX_W = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;

  typedef enum logic [2:0] {B_IDLE, B_DIV1, B_DIV2, B_SQRT, B_EMIT} bstate_t;

  logic [DATA_W-1:0] wt_mem  [MAX_HIDDEN];
  logic [DATA_W-1:0] row_mem [MAX_HIDDEN];

  bstate_t             st_r;
  logic [5:0]          step_r;
  logic [DIVD_W-1:0]   dd_r;
  logic [MS_W-1:0]     rem_r;
  logic [MS_W-1:0]     dv_r;
  logic [DIVD_W-1:0]   quo_r;
  logic [DIVD_W:0]     res_r;
  logic [DIVD_W-1:0]   bit_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    n_r;
  logic [CNT_W-1:0]    idx_r;

  logic signed [DATA_W-1:0] x_r, w_r;
  logic signed [31:0]       xw_r;
  logic signed [61:0]       p_r;
  logic                     v0_r, v1_r, v2_r, l0_r, l1_r, l2_r;
  logic                     ov_r;
  out_word_t                ow_r;

  logic [MS_W:0]       trial;
  logic                tgo;
  logic [MS_W-1:0]     ms;
  logic [DIVD_W:0]     sq_t;
  logic                sq_go;
  logic                adv;
  logic                issue;
  logic [61:0]         mag;
  logic [31:0]         qmag;
  logic signed [DATA_W-1:0] ysat;

  assign trial = {rem_r, dd_r[DIVD_W-1]};
  assign tgo   = trial >= {1'b0, dv_r};
  // quotient including the bit of the final divide step, plus epsilon
  assign ms    = {quo_r[MS_W-2:0], tgo} + {13'd0, eps};
  assign sq_t  = res_r + {1'b0, bit_r};
  assign sq_go = {1'b0, quo_r} >= sq_t;

  assign adv   = !(ov_r && out_stall);
  assign issue = (st_r == B_EMIT) && adv && (idx_r < n_r);

  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign busy      = (st_r != B_IDLE);
  assign out_valid = ov_r;
  assign out_word  = ow_r;

  // round half away from zero, then saturate
  always_comb begin
    mag  = p_r[61] ? 62'(-p_r) : 62'(p_r);
    qmag = 32'((mag + 62'd536870912) >> 30);
    if (p_r[61]) begin
      ysat = (qmag > 32'd32768) ? -16'sd32768 : DATA_W'(-$signed(qmag));
    end else begin
      ysat = (qmag > 32'd32767) ? 16'sd32767 : DATA_W'(qmag);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_w) wt_mem[wr.addr[IDX_W-1:0]] <= wr.data;
    if (wr.we_x) row_mem[wr.addr[IDX_W-1:0]] <= wr.data;
    if (issue) begin
      x_r <= $signed(row_mem[idx_r[IDX_W-1:0]]);
      w_r <= $signed(wt_mem[idx_r[IDX_W-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xw_r <= x_r * w_r;
      p_r  <= xw_r * $signed({1'b0, root_r});
      ow_r <= '{y_value: ysat, last_out: l2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      step_r <= '0;
      idx_r <= '0;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (adv) begin
        v0_r <= issue;
        l0_r <= (idx_r + 7'd1 == n_r);
        v1_r <= v0_r;
        l1_r <= l0_r;
        v2_r <= v1_r;
        l2_r <= l1_r;
        ov_r <= v2_r;
      end
      if (issue) idx_r <= idx_r + 7'd1;
      case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            dd_r   <= {21'd0, q_job.sum};
            dv_r   <= {30'd0, q_job.count};
            n_r    <= q_job.count;
            rem_r  <= '0;
            quo_r  <= '0;
            step_r <= '0;
            st_r   <= B_DIV1;
          end
        end
        B_DIV1, B_DIV2: begin
          if (step_r == 6'(DIV_STEPS - 1)) begin
            step_r <= '0;
            if (st_r == B_DIV1) begin
              // mean square of the row plus epsilon, never zero
              dv_r  <= (ms == '0) ? MS_W'(1) : ms;
              dd_r  <= {1'b1, 56'd0};
              rem_r <= '0;
              quo_r <= '0;
              st_r  <= B_DIV2;
            end else begin
              quo_r <= {quo_r[DIVD_W-2:0], tgo};
              res_r <= '0;
              bit_r <= {1'b1, 56'd0};
              st_r  <= B_SQRT;
            end
          end else begin
            rem_r  <= tgo ? MS_W'(trial - {1'b0, dv_r}) : trial[MS_W-1:0];
            dd_r   <= {dd_r[DIVD_W-2:0], 1'b0};
            quo_r  <= {quo_r[DIVD_W-2:0], tgo};
            step_r <= step_r + 6'd1;
          end
        end
        B_SQRT: begin
          if (sq_go) begin
            quo_r <= DIVD_W'({1'b0, quo_r} - sq_t);
            res_r <= (res_r >> 1) + {1'b0, bit_r};
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          step_r <= step_r + 6'd1;
          if (step_r == 6'(SQRT_STEPS - 1)) begin
            st_r <= B_EMIT;
            idx_r <= '0;
          end
        end
        B_EMIT: begin
          if (idx_r == n_r && !v0_r && !v1_r && !v2_r && !ov_r) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // root is held steady through the whole emit phase
  always_ff @(posedge clk) begin
    if (st_r == B_SQRT && step_r == 6'(SQRT_STEPS - 1)) begin
      root_r <= sq_go ? ROOT_W'((res_r >> 1) + {1'b0, bit_r}) : ROOT_W'(res_r >> 1);
    end
  end

endmodule

FILE: rtl/core/rms_vector_normalizer.sv
// The last word of a row reaches the back end in the next cycle; the back end runs the
// divider for mean square plus epsilon, then for its scaled reciprocal, then the root
// unit, and sends each sample through operand, product, scaled and output registers,
// giving one result a cycle while out_stall is low. Input is taken at one word a cycle
// while in_stall is low, and stalls from a row's last word until the back end is idle.
// Reset: synchronous, active low; clears sums, counts, queue and control state.
module rms_vector_normalizer import rvn_pkg::*; #(
  parameter int MAX_HIDDEN = MaxHiddenDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [EPS_W-1:0] eps_r;
  logic             in_acc;
  wr_t              wr;
  logic             push;
  job_t             job;
  logic             q_pop;
  job_t             q_job;
  logic             q_empty;
  logic             q_full;
  logic             back_busy;

  // epsilon register; the user must write it only while idle, the block does not enforce this
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_EPS) ? {8'd0, eps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_EPS) begin
      eps_r <= pwdata[EPS_W-1:0];
    end
  end

  // hold the input while a row waits in the queue or is being worked on:
  // the row buffer and weights belong to the back end until it finishes
  assign in_stall = !q_empty || back_busy;
  assign in_acc   = in_valid && !in_stall;

  rvn_front #(.MAX_HIDDEN(MAX_HIDDEN)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .word  (in_word),
    .wr    (wr),
    .push  (push),
    .job   (job)
  );

  rvn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  rvn_back #(.MAX_HIDDEN(MAX_HIDDEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .eps       (eps_r),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTH
  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_empty && !back_busy && !q_full))
    else $error("row posted while another is outstanding");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_word.last_out) |=> !out_valid)
    else $error("result after the last one of a row");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> back_busy)
    else $error("result while back end idle");
`endif

endmodule
